// ===== rtl/core/point_rotate_about_pivot_core_defines.svh =====
// Assertion macros shared by the point rotation RTL
`ifndef POINT_ROTATE_ABOUT_PIVOT_CORE_DEFINES_SVH
`define POINT_ROTATE_ABOUT_PIVOT_CORE_DEFINES_SVH

// same-cycle implication, off while reset is high
`define PRP_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, off while reset is high
`define PRP_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== rtl/core/prp_pkg.sv =====
// Types, constants and the arctangent table of the point rotation core
`timescale 1ns / 1ps
package prp_pkg;

   localparam int COORD_W      = 12;
   localparam int DIFF_W       = COORD_W + 1;
   localparam int OUT_W        = COORD_W + 2;
   localparam int ANGLE_W      = 16;
   localparam int FRAC_BITS    = 16;
   localparam int CS_W         = FRAC_BITS + 2;
   localparam int XY_W         = FRAC_BITS + 4;
   localparam int Z_W          = FRAC_BITS + 10;
   localparam int PROD_W       = DIFF_W + CS_W;
   localparam int SUM_W        = PROD_W + 2;

   localparam int CORDIC_STAGES = 16;
   localparam int ATAN_ENTRIES  = 24;
   localparam int CORDIC_CELLS  = (CORDIC_STAGES > ATAN_ENTRIES) ? ATAN_ENTRIES
                                                                 : CORDIC_STAGES;
   localparam int STAGE_IDX_W   = $clog2(ATAN_ENTRIES);

   localparam int FULL_TURN    = 360;
   localparam int QUARTER_TURN = 90;
   // 92 full turns: lifts every 16-bit signed angle to a non-negative value
   localparam int ANGLE_OFFSET = 92 * FULL_TURN;
   localparam int U_W          = ANGLE_W + 1;
   localparam int RECIP_W      = 16;
   localparam int RECIP_SHIFT  = 24;
   // floor(2^24 / 360): quotient estimate is exact or one low
   localparam logic [RECIP_W-1:0] RECIP_360 = RECIP_W'((1 << RECIP_SHIFT) / FULL_TURN);
   localparam int RPROD_W      = U_W + RECIP_W;
   localparam int QEST_W       = RPROD_W - RECIP_SHIFT;
   localparam int REM_W        = $clog2(FULL_TURN);
   localparam int M_W          = $clog2(QUARTER_TURN);

   localparam logic signed [XY_W-1:0] GAIN_Q16 = XY_W'(39797);
   localparam logic signed [CS_W-1:0] ONE_Q16  = CS_W'(1 << FRAC_BITS);

   localparam int REQ_DATA_W = 2 * COORD_W + ANGLE_W;
   localparam int RSP_DATA_W = ((2 * OUT_W + 7) / 8) * 8;
   localparam int RSP_PAD_W  = RSP_DATA_W - 2 * OUT_W;

   localparam int CSR_IDX_W = 2;
   localparam logic [CSR_IDX_W-1:0] CSR_PIVOT_X = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] CSR_PIVOT_Y = CSR_IDX_W'(1);

   typedef enum logic [1:0] {
      QUAD_0,
      QUAD_1,
      QUAD_2,
      QUAD_3
   } quad_type;

   // state handed from cell to cell
   typedef struct packed {
      logic signed [DIFF_W-1:0] dx;
      logic signed [DIFF_W-1:0] dy;
      quad_type                 quad;
      logic                     bypass;
      logic signed [XY_W-1:0]   x;
      logic signed [XY_W-1:0]   y;
      logic signed [Z_W-1:0]    z;
   } token_type;

   // atan(2^-i) in degrees, Q16
   function automatic logic signed [Z_W-1:0] atan_q16(input logic [STAGE_IDX_W-1:0] idx);
      logic signed [Z_W-1:0] val;
      unique case (idx)
         5'd0:    val = Z_W'(2949120);
         5'd1:    val = Z_W'(1740967);
         5'd2:    val = Z_W'(919879);
         5'd3:    val = Z_W'(466945);
         5'd4:    val = Z_W'(234379);
         5'd5:    val = Z_W'(117304);
         5'd6:    val = Z_W'(58666);
         5'd7:    val = Z_W'(29335);
         5'd8:    val = Z_W'(14668);
         5'd9:    val = Z_W'(7334);
         5'd10:   val = Z_W'(3667);
         5'd11:   val = Z_W'(1833);
         5'd12:   val = Z_W'(917);
         5'd13:   val = Z_W'(458);
         5'd14:   val = Z_W'(229);
         5'd15:   val = Z_W'(115);
         5'd16:   val = Z_W'(57);
         5'd17:   val = Z_W'(29);
         5'd18:   val = Z_W'(14);
         5'd19:   val = Z_W'(7);
         5'd20:   val = Z_W'(4);
         5'd21:   val = Z_W'(2);
         5'd22:   val = Z_W'(1);
         default: val = '0;
      endcase
      return val;
   endfunction

endpackage

// ===== rtl/core/point_rotate_about_pivot_core.sv =====
// Top level of the point rotation core: pivot registers and the cell chain
`timescale 1ns / 1ps
// Rotates each request point about the pivot by a whole-degree angle and returns one
// result per request. The core is a pipeline of cells (angle reduction, one cell per
// CORDIC iteration, then quadrant fold, products, sums and truncation); each cell hands
// its item on every cycle when the result side keeps up, so one request then enters
// per clock; a result passes the reduce, CORDIC and combine registers in turn.
// Each cell holds its item and passes it on when the next one is free, so empty slots
// are filled while the result register waits. The pivot port is always ready; write it
// only while no request is in flight.
module point_rotate_about_pivot_core (
   input  logic                                 clock,
   input  logic                                 reset,
   // request: point_x [11:0], point_y [23:12], angle_deg [39:24]
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   input  logic [prp_pkg::REQ_DATA_W-1:0]       req_tdata,
   // result: rot_x [13:0], rot_y [27:14], zero [31:28]
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   output logic [prp_pkg::RSP_DATA_W-1:0]       rsp_tdata,
   // pivot registers: 0 pivot_x, 1 pivot_y
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [prp_pkg::CSR_IDX_W-1:0]        csr_index,
   input  logic [prp_pkg::COORD_W-1:0]          csr_data
);

   logic signed [prp_pkg::COORD_W-1:0]  pivot_x_ff, pivot_y_ff;
   logic signed [prp_pkg::COORD_W-1:0]  point_x, point_y;
   logic signed [prp_pkg::ANGLE_W-1:0]  angle_deg;
   logic signed [prp_pkg::OUT_W-1:0]    rot_x, rot_y;

   prp_pkg::token_type                  chain_tok   [prp_pkg::CORDIC_CELLS+1];
   logic                                chain_valid [prp_pkg::CORDIC_CELLS+1];
   logic                                chain_ready [prp_pkg::CORDIC_CELLS+1];

   assign csr_ready = 1'b1;
   assign point_x   = req_tdata[prp_pkg::COORD_W-1:0];
   assign point_y   = req_tdata[2*prp_pkg::COORD_W-1:prp_pkg::COORD_W];
   assign angle_deg = req_tdata[prp_pkg::REQ_DATA_W-1:2*prp_pkg::COORD_W];
   assign rsp_tdata = {{prp_pkg::RSP_PAD_W{1'b0}}, rot_y, rot_x};

   always_ff @(posedge clock) begin
      if (reset) begin
         pivot_x_ff <= '0;
         pivot_y_ff <= '0;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            prp_pkg::CSR_PIVOT_X: pivot_x_ff <= csr_data;
            prp_pkg::CSR_PIVOT_Y: pivot_y_ff <= csr_data;
            default: ;
         endcase
      end
   end

   prp_reduce u_reduce (
      .clock     (clock),
      .reset     (reset),
      .pivot_x   (pivot_x_ff),
      .pivot_y   (pivot_y_ff),
      .in_valid  (req_tvalid),
      .in_ready  (req_tready),
      .point_x   (point_x),
      .point_y   (point_y),
      .angle_deg (angle_deg),
      .out_valid (chain_valid[0]),
      .out_ready (chain_ready[0]),
      .out_tok   (chain_tok[0])
   );

   for (genvar i = 0; i < prp_pkg::CORDIC_CELLS; i++) begin : g_cell
      prp_cordic_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .stage_idx (prp_pkg::STAGE_IDX_W'(i)),
         .in_valid  (chain_valid[i]),
         .in_ready  (chain_ready[i]),
         .in_tok    (chain_tok[i]),
         .out_valid (chain_valid[i+1]),
         .out_ready (chain_ready[i+1]),
         .out_tok   (chain_tok[i+1])
      );
   end

   prp_combine u_combine (
      .clock     (clock),
      .reset     (reset),
      .pivot_x   (pivot_x_ff),
      .pivot_y   (pivot_y_ff),
      .in_valid  (chain_valid[prp_pkg::CORDIC_CELLS]),
      .in_ready  (chain_ready[prp_pkg::CORDIC_CELLS]),
      .in_tok    (chain_tok[prp_pkg::CORDIC_CELLS]),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .rot_x     (rot_x),
      .rot_y     (rot_y)
   );

endmodule

// ===== rtl/core/prp_reduce.sv =====
// Angle reduction to quadrant and remainder, offsets from the pivot
`timescale 1ns / 1ps
`include "point_rotate_about_pivot_core_defines.svh"
module prp_reduce (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic signed [prp_pkg::COORD_W-1:0]     pivot_x,
   input  logic signed [prp_pkg::COORD_W-1:0]     pivot_y,
   input  logic                                   in_valid,
   output logic                                   in_ready,
   input  logic signed [prp_pkg::COORD_W-1:0]     point_x,
   input  logic signed [prp_pkg::COORD_W-1:0]     point_y,
   input  logic signed [prp_pkg::ANGLE_W-1:0]     angle_deg,
   output logic                                   out_valid,
   input  logic                                   out_ready,
   output prp_pkg::token_type                     out_tok
);

   // stage 1: reciprocal product
   logic                                  v1_ff;
   logic                                  rdy1;
   logic [prp_pkg::U_W-1:0]               u_in, u_ff;
   logic [prp_pkg::RPROD_W-1:0]           rprod_in, rprod_ff;
   logic signed [prp_pkg::DIFF_W-1:0]     dx_in, dy_in, dx1_ff, dy1_ff;
   // stage 2: remainder
   logic                                  v2_ff;
   logic                                  rdy2;
   logic [prp_pkg::QEST_W-1:0]            qest;
   logic [prp_pkg::U_W-1:0]               rpre;
   logic [prp_pkg::REM_W-1:0]             rem_in, rem_ff;
   logic signed [prp_pkg::DIFF_W-1:0]     dx2_ff, dy2_ff;
   // stage 3: quadrant split
   logic                                  v3_ff;
   logic                                  rdy3;
   prp_pkg::quad_type                     quad_in;
   logic [prp_pkg::M_W-1:0]               m_in;
   prp_pkg::token_type                    tok_in, tok_ff;

   assign out_valid = v3_ff;
   assign out_tok   = tok_ff;
   assign rdy3      = !v3_ff || out_ready;
   assign rdy2      = !v2_ff || rdy3;
   assign rdy1      = !v1_ff || rdy2;
   assign in_ready  = rdy1;

   always_comb begin
      u_in     = prp_pkg::U_W'($signed({angle_deg[prp_pkg::ANGLE_W-1], angle_deg})
                               + (prp_pkg::U_W + 1)'(prp_pkg::ANGLE_OFFSET));
      rprod_in = prp_pkg::RPROD_W'(u_in) * prp_pkg::RPROD_W'(prp_pkg::RECIP_360);
      dx_in    = prp_pkg::DIFF_W'(point_x) - prp_pkg::DIFF_W'(pivot_x);
      dy_in    = prp_pkg::DIFF_W'(point_y) - prp_pkg::DIFF_W'(pivot_y);
   end

   always_comb begin
      qest = rprod_ff[prp_pkg::RECIP_SHIFT +: prp_pkg::QEST_W];
      rpre = u_ff - prp_pkg::U_W'(qest) * prp_pkg::U_W'(prp_pkg::FULL_TURN);
      // estimate may be one low: fold the extra turn
      if (rpre >= prp_pkg::U_W'(prp_pkg::FULL_TURN)) begin
         rem_in = prp_pkg::REM_W'(rpre - prp_pkg::U_W'(prp_pkg::FULL_TURN));
      end else begin
         rem_in = prp_pkg::REM_W'(rpre);
      end
   end

   always_comb begin
      if (rem_ff >= prp_pkg::REM_W'(3 * prp_pkg::QUARTER_TURN)) begin
         quad_in = prp_pkg::QUAD_3;
         m_in    = prp_pkg::M_W'(rem_ff - prp_pkg::REM_W'(3 * prp_pkg::QUARTER_TURN));
      end else if (rem_ff >= prp_pkg::REM_W'(2 * prp_pkg::QUARTER_TURN)) begin
         quad_in = prp_pkg::QUAD_2;
         m_in    = prp_pkg::M_W'(rem_ff - prp_pkg::REM_W'(2 * prp_pkg::QUARTER_TURN));
      end else if (rem_ff >= prp_pkg::REM_W'(prp_pkg::QUARTER_TURN)) begin
         quad_in = prp_pkg::QUAD_1;
         m_in    = prp_pkg::M_W'(rem_ff - prp_pkg::REM_W'(prp_pkg::QUARTER_TURN));
      end else begin
         quad_in = prp_pkg::QUAD_0;
         m_in    = prp_pkg::M_W'(rem_ff);
      end
      tok_in.dx     = dx2_ff;
      tok_in.dy     = dy2_ff;
      tok_in.quad   = quad_in;
      tok_in.bypass = (m_in == '0);
      tok_in.x      = prp_pkg::GAIN_Q16;
      tok_in.y      = '0;
      tok_in.z      = prp_pkg::Z_W'({m_in, {prp_pkg::FRAC_BITS{1'b0}}});
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else begin
         if (rdy1) begin
            v1_ff <= in_valid;
         end
         if (rdy2) begin
            v2_ff <= v1_ff;
         end
         if (rdy3) begin
            v3_ff <= v2_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (rdy1 && in_valid) begin
         u_ff     <= u_in;
         rprod_ff <= rprod_in;
         dx1_ff   <= dx_in;
         dy1_ff   <= dy_in;
      end
      if (rdy2 && v1_ff) begin
         rem_ff <= rem_in;
         dx2_ff <= dx1_ff;
         dy2_ff <= dy1_ff;
      end
      if (rdy3 && v2_ff) begin
         tok_ff <= tok_in;
      end
   end

   `PRP_ASSERT_IMP(a_rem_range, clock, reset, v2_ff, rem_ff < prp_pkg::REM_W'(prp_pkg::FULL_TURN), "angle remainder out of range")
   `PRP_ASSERT_IMP(a_z_start, clock, reset, v3_ff, tok_ff.z >= 0 && tok_ff.z < prp_pkg::Z_W'(prp_pkg::QUARTER_TURN << prp_pkg::FRAC_BITS), "cordic start angle out of quadrant")
   `PRP_ASSERT_NXT(a_out_hold, clock, reset, v3_ff && !out_ready, v3_ff && $stable(tok_ff), "reduced request changed while stalled")

endmodule

// ===== rtl/core/prp_cordic_cell.sv =====
// One rotation-mode CORDIC iteration as a pipeline cell
`timescale 1ns / 1ps
`include "point_rotate_about_pivot_core_defines.svh"
module prp_cordic_cell (
   input  logic                                clock,
   input  logic                                reset,
   input  logic [prp_pkg::STAGE_IDX_W-1:0]     stage_idx,
   input  logic                                in_valid,
   output logic                                in_ready,
   input  prp_pkg::token_type                  in_tok,
   output logic                                out_valid,
   input  logic                                out_ready,
   output prp_pkg::token_type                  out_tok
);

   logic                               valid_ff;
   prp_pkg::token_type                 tok_in, tok_ff;
   logic signed [prp_pkg::XY_W-1:0]    x_cur, y_cur, x_sh, y_sh;
   logic signed [prp_pkg::Z_W-1:0]     z_cur, atan_val;

   assign in_ready  = !valid_ff || out_ready;
   assign out_valid = valid_ff;
   assign out_tok   = tok_ff;

   always_comb begin
      x_cur    = in_tok.x;
      y_cur    = in_tok.y;
      z_cur    = in_tok.z;
      x_sh     = x_cur >>> stage_idx;
      y_sh     = y_cur >>> stage_idx;
      atan_val = prp_pkg::atan_q16(stage_idx);
      tok_in   = in_tok;
      // rotate toward zero residual angle
      if (!z_cur[prp_pkg::Z_W-1]) begin
         tok_in.x = x_cur - y_sh;
         tok_in.y = y_cur + x_sh;
         tok_in.z = z_cur - atan_val;
      end else begin
         tok_in.x = x_cur + y_sh;
         tok_in.y = y_cur - x_sh;
         tok_in.z = z_cur + atan_val;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         tok_ff <= tok_in;
      end
   end

   `PRP_ASSERT_NXT(a_cell_hold, clock, reset, valid_ff && !out_ready, valid_ff, "cell dropped a stalled request")
   `PRP_ASSERT_NXT(a_cell_stable, clock, reset, valid_ff && !out_ready, $stable(tok_ff), "cell changed a stalled request")
   `PRP_ASSERT_IMP(a_cell_free, clock, reset, !valid_ff, in_ready, "empty cell not ready")

endmodule

// ===== rtl/core/prp_combine.sv =====
// Quadrant fold, products, sums and truncation onto the result channel
`timescale 1ns / 1ps
`include "point_rotate_about_pivot_core_defines.svh"
module prp_combine (
   input  logic                                clock,
   input  logic                                reset,
   input  logic signed [prp_pkg::COORD_W-1:0]  pivot_x,
   input  logic signed [prp_pkg::COORD_W-1:0]  pivot_y,
   input  logic                                in_valid,
   output logic                                in_ready,
   input  prp_pkg::token_type                  in_tok,
   output logic                                out_valid,
   input  logic                                out_ready,
   output logic signed [prp_pkg::OUT_W-1:0]    rot_x,
   output logic signed [prp_pkg::OUT_W-1:0]    rot_y
);

   logic                               v1_ff, v2_ff, v3_ff, v4_ff;
   logic                               rdy1, rdy2, rdy3, rdy4;
   // stage 1
   logic signed [prp_pkg::CS_W-1:0]    xc, yc, c_in, s_in, c_ff, s_ff;
   logic signed [prp_pkg::DIFF_W-1:0]  dx1_ff, dy1_ff;
   // stage 2
   logic signed [prp_pkg::PROD_W-1:0]  pxc_ff, pys_ff, pxs_ff, pyc_ff;
   // stage 3
   logic signed [prp_pkg::SUM_W-1:0]   sx_in, sy_in, sx_ff, sy_ff;
   // stage 4
   logic signed [prp_pkg::SUM_W-1:0]   tx, ty, bias_x, bias_y;
   logic signed [prp_pkg::OUT_W-1:0]   rx_in, ry_in, rx_ff, ry_ff;

   assign rdy4      = !v4_ff || out_ready;
   assign rdy3      = !v3_ff || rdy4;
   assign rdy2      = !v2_ff || rdy3;
   assign rdy1      = !v1_ff || rdy2;
   assign in_ready  = rdy1;
   assign out_valid = v4_ff;
   assign rot_x     = rx_ff;
   assign rot_y     = ry_ff;

   function automatic logic signed [prp_pkg::CS_W-1:0] clamp_one(
      input logic signed [prp_pkg::XY_W-1:0] v);
      logic signed [prp_pkg::CS_W-1:0] r;
      if (v > prp_pkg::XY_W'(prp_pkg::ONE_Q16)) begin
         r = prp_pkg::ONE_Q16;
      end else if (v < -prp_pkg::XY_W'(prp_pkg::ONE_Q16)) begin
         r = -prp_pkg::ONE_Q16;
      end else begin
         r = prp_pkg::CS_W'(v);
      end
      return r;
   endfunction

   always_comb begin
      if (in_tok.bypass) begin
         xc = prp_pkg::ONE_Q16;
         yc = '0;
      end else begin
         xc = clamp_one(in_tok.x);
         yc = clamp_one(in_tok.y);
      end
      unique case (in_tok.quad)
         prp_pkg::QUAD_0: begin c_in = xc;  s_in = yc;  end
         prp_pkg::QUAD_1: begin c_in = -yc; s_in = xc;  end
         prp_pkg::QUAD_2: begin c_in = -xc; s_in = -yc; end
         prp_pkg::QUAD_3: begin c_in = yc;  s_in = -xc; end
      endcase
   end

   always_comb begin
      sx_in = $signed({pivot_x, {prp_pkg::FRAC_BITS{1'b0}}})
              + prp_pkg::SUM_W'(pxc_ff) - prp_pkg::SUM_W'(pys_ff);
      sy_in = $signed({pivot_y, {prp_pkg::FRAC_BITS{1'b0}}})
              + prp_pkg::SUM_W'(pxs_ff) + prp_pkg::SUM_W'(pyc_ff);
   end

   always_comb begin
      // truncate toward zero: bias negative sums before the shift
      bias_x = sx_ff[prp_pkg::SUM_W-1] ? prp_pkg::SUM_W'((1 << prp_pkg::FRAC_BITS) - 1) : '0;
      bias_y = sy_ff[prp_pkg::SUM_W-1] ? prp_pkg::SUM_W'((1 << prp_pkg::FRAC_BITS) - 1) : '0;
      tx     = (sx_ff + bias_x) >>> prp_pkg::FRAC_BITS;
      ty     = (sy_ff + bias_y) >>> prp_pkg::FRAC_BITS;
      rx_in  = tx[prp_pkg::OUT_W-1:0];
      ry_in  = ty[prp_pkg::OUT_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
      end else begin
         if (rdy1) begin
            v1_ff <= in_valid;
         end
         if (rdy2) begin
            v2_ff <= v1_ff;
         end
         if (rdy3) begin
            v3_ff <= v2_ff;
         end
         if (rdy4) begin
            v4_ff <= v3_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (rdy1 && in_valid) begin
         c_ff   <= c_in;
         s_ff   <= s_in;
         dx1_ff <= in_tok.dx;
         dy1_ff <= in_tok.dy;
      end
      if (rdy2 && v1_ff) begin
         pxc_ff <= prp_pkg::PROD_W'(dx1_ff) * prp_pkg::PROD_W'(c_ff);
         pys_ff <= prp_pkg::PROD_W'(dy1_ff) * prp_pkg::PROD_W'(s_ff);
         pxs_ff <= prp_pkg::PROD_W'(dx1_ff) * prp_pkg::PROD_W'(s_ff);
         pyc_ff <= prp_pkg::PROD_W'(dy1_ff) * prp_pkg::PROD_W'(c_ff);
      end
      if (rdy3 && v2_ff) begin
         sx_ff <= sx_in;
         sy_ff <= sy_in;
      end
      if (rdy4 && v3_ff) begin
         rx_ff <= rx_in;
         ry_ff <= ry_in;
      end
   end

   `PRP_ASSERT_IMP(a_cos_range, clock, reset, v1_ff, c_ff <= prp_pkg::ONE_Q16 && c_ff >= -prp_pkg::ONE_Q16 && s_ff <= prp_pkg::ONE_Q16 && s_ff >= -prp_pkg::ONE_Q16, "sine or cosine beyond unity")
   `PRP_ASSERT_NXT(a_out_hold, clock, reset, v4_ff && !out_ready, v4_ff && $stable(rx_ff) && $stable(ry_ff), "result changed while stalled")
   `PRP_ASSERT_IMP(a_in_free, clock, reset, !v1_ff, in_ready, "empty input stage not ready")

endmodule

// ===== dv/testbench.sv =====
`timescale 1ns / 1ps
// Testbench for the point rotation core: directed and random points against a CORDIC predictor
module testbench;

   localparam int COORD_W    = prp_pkg::COORD_W;
   localparam int ANGLE_W    = prp_pkg::ANGLE_W;
   localparam int OUT_W      = prp_pkg::OUT_W;
   localparam int REQ_DATA_W = prp_pkg::REQ_DATA_W;
   localparam int RSP_DATA_W = prp_pkg::RSP_DATA_W;
   localparam int CSR_IDX_W  = prp_pkg::CSR_IDX_W;

   localparam int COORD_MIN = -(1 << (COORD_W - 1));
   localparam int COORD_MAX = (1 << (COORD_W - 1)) - 1;

   // indexes past the pivot registers; writes there must leave the pivot alone
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_A = CSR_IDX_W'(2);
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_B = CSR_IDX_W'(3);

   localparam int     DEG_PER_TURN     = 360;
   localparam int     DEG_PER_QUADRANT = 90;
   localparam longint UNIT_Q16         = 64'sd65536;
   localparam longint GAIN_Q16         = 64'sd39797;
   localparam int     ATAN_ENTRIES     = 24;
   localparam int     CORDIC_ITERS     = (prp_pkg::CORDIC_STAGES > ATAN_ENTRIES) ? ATAN_ENTRIES
                                                                               : prp_pkg::CORDIC_STAGES;

   localparam int PIPE_LATENCY = 7 + CORDIC_ITERS;
   localparam int TAIL_CYCLES  = 2 * PIPE_LATENCY;
   localparam int IDLE_LIMIT   = 2000;
   localparam int LONG_HOLD    = 300;

   typedef struct packed {
      logic [OUT_W-1:0] rot_x;
      logic [OUT_W-1:0] rot_y;
   } rotated_point_type;

   typedef enum int {
      SINK_ALWAYS,
      SINK_PATTERN,
      SINK_RANDOM
   } sink_mode_type;

   logic                  clock      = 1'b0;
   logic                  reset      = 1'b1;
   logic                  req_tvalid = 1'b0;
   wire                   req_tready;
   logic [REQ_DATA_W-1:0] req_tdata  = '0;
   wire                   rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   wire  [RSP_DATA_W-1:0] rsp_tdata;
   logic                  csr_valid  = 1'b0;
   wire                   csr_ready;
   logic [CSR_IDX_W-1:0]  csr_index  = '0;
   logic [COORD_W-1:0]    csr_data   = '0;

   longint            cur_pivot_x = 0;
   longint            cur_pivot_y = 0;
   rotated_point_type pending_rotations[$];
   int                error_count = 0;
   int                idle_cycles = 0;

   int                burst_left = 0;
   int                gap_max    = 0;
   sink_mode_type     sink_mode  = SINK_ALWAYS;
   int                hold_rsp_cycles = 0;
   logic [15:0]       sink_pattern = 16'hb5a7;
   int                pattern_age  = 0;

   always #10 clock = ~clock;

   point_rotate_about_pivot_core i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   // atan(2^-i) in degrees, Q16
   function automatic longint atan_deg_q16(input int i);
      case (i)
         0:       return 2949120;
         1:       return 1740967;
         2:       return 919879;
         3:       return 466945;
         4:       return 234379;
         5:       return 117304;
         6:       return 58666;
         7:       return 29335;
         8:       return 14668;
         9:       return 7334;
         10:      return 3667;
         11:      return 1833;
         12:      return 917;
         13:      return 458;
         14:      return 229;
         15:      return 115;
         16:      return 57;
         17:      return 29;
         18:      return 14;
         19:      return 7;
         20:      return 4;
         21:      return 2;
         22:      return 1;
         default: return 0;
      endcase
   endfunction

   function automatic void sincos_deg(input int deg, output longint c, output longint s);
      int                r;
      int                m;
      longint            x;
      longint            y;
      longint            z;
      longint            t;
      prp_pkg::quad_type q;
      r = deg % DEG_PER_TURN;
      if (r < 0) r += DEG_PER_TURN;
      q = prp_pkg::quad_type'(r / DEG_PER_QUADRANT);
      m = r % DEG_PER_QUADRANT;
      if (m == 0) begin
         // whole quadrants are exact
         x = UNIT_Q16;
         y = 0;
      end else begin
         x = GAIN_Q16;
         y = 0;
         z = longint'(m) * UNIT_Q16;
         for (int i = 0; i < CORDIC_ITERS; i++) begin
            if (z >= 0) begin
               t = x - (y >>> i);
               y = y + (x >>> i);
               z = z - atan_deg_q16(i);
            end else begin
               t = x + (y >>> i);
               y = y - (x >>> i);
               z = z + atan_deg_q16(i);
            end
            x = t;
         end
         if (x > UNIT_Q16) x = UNIT_Q16;
         if (x < -UNIT_Q16) x = -UNIT_Q16;
         if (y > UNIT_Q16) y = UNIT_Q16;
         if (y < -UNIT_Q16) y = -UNIT_Q16;
      end
      case (q)
         prp_pkg::QUAD_1: begin c = -y; s = x;  end
         prp_pkg::QUAD_2: begin c = -x; s = -y; end
         prp_pkg::QUAD_3: begin c = y;  s = -x; end
         default:         begin c = x;  s = y;  end
      endcase
   endfunction

   function automatic rotated_point_type rotate_point(input longint px, input longint py,
                                                      input int ang);
      longint            c;
      longint            s;
      longint            dx;
      longint            dy;
      longint            sx;
      longint            sy;
      longint            rx;
      longint            ry;
      rotated_point_type r;
      sincos_deg(ang, c, s);
      dx = px - cur_pivot_x;
      dy = py - cur_pivot_y;
      // truncate the whole sum, pivot included
      sx = cur_pivot_x * UNIT_Q16 + dx * c - dy * s;
      sy = cur_pivot_y * UNIT_Q16 + dx * s + dy * c;
      rx = sx / UNIT_Q16;
      ry = sy / UNIT_Q16;
      r.rot_x = rx[OUT_W-1:0];
      r.rot_y = ry[OUT_W-1:0];
      return r;
   endfunction

   function automatic int rand_coord();
      case ($urandom_range(0, 9))
         0:       return COORD_MIN;
         1:       return COORD_MAX;
         2:       return int'($urandom_range(0, 16)) - 8;
         default: return int'($urandom_range(0, 4095)) - 2048;
      endcase
   endfunction

   function automatic int rand_angle();
      case ($urandom_range(0, 3))
         0:       return DEG_PER_QUADRANT * (int'($urandom_range(0, 728)) - 364);
         1:       return int'($urandom_range(0, DEG_PER_TURN - 1));
         default: return int'($urandom_range(0, 65535)) - 32768;
      endcase
   endfunction

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      error_count++;
      if (error_count <= 100)
         $display("%0t mismatch in %s: got %h, expected %h", $time, what, got, want);
   endtask

   task automatic send_point(input int px, input int py, input int ang);
      int                          gap;
      logic signed [COORD_W-1:0]   x;
      logic signed [COORD_W-1:0]   y;
      logic signed [ANGLE_W-1:0]   a;
      x = COORD_W'(px);
      y = COORD_W'(py);
      a = ANGLE_W'(ang);
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 16);
         gap = (gap_max > 0) ? $urandom_range(0, gap_max) : 0;
         if (gap > 0) begin
            @(negedge clock);
            req_tvalid <= 1'b0;
            repeat (gap - 1) @(negedge clock);
         end
      end
      @(negedge clock);
      req_tvalid <= 1'b1;
      req_tdata  <= {a, y, x};
      do @(posedge clock); while (!req_tready);
      pending_rotations.push_back(rotate_point(x, y, a));
      burst_left--;
   endtask

   // stop offering requests and wait for every result to come back
   task automatic drain_rotations();
      @(negedge clock);
      req_tvalid <= 1'b0;
      burst_left = 0;
      while (pending_rotations.size() != 0) @(posedge clock);
   endtask

   task automatic write_register(input logic [CSR_IDX_W-1:0] idx, input int value);
      logic signed [COORD_W-1:0] v;
      v = COORD_W'(value);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= v;
      do @(posedge clock); while (!csr_ready);
      case (idx)
         prp_pkg::CSR_PIVOT_X: cur_pivot_x = v;
         prp_pkg::CSR_PIVOT_Y: cur_pivot_y = v;
         default: ;
      endcase
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic set_pivot(input int x, input int y);
      drain_rotations();
      write_register(prp_pkg::CSR_PIVOT_X, x);
      write_register(prp_pkg::CSR_PIVOT_Y, y);
   endtask

   task automatic test_angle_cases();
      gap_max   = 3;
      sink_mode = SINK_RANDOM;
      send_point(COORD_MAX, COORD_MIN, 0);
      send_point(COORD_MIN, COORD_MAX, 90);
      send_point(COORD_MAX, COORD_MAX, 180);
      send_point(COORD_MIN, COORD_MIN, 270);
      send_point(1000, -500, 360);
      send_point(-1, 1, -90);
      send_point(COORD_MAX, 0, 45);
      send_point(0, COORD_MAX, 1);
      send_point(COORD_MIN, 0, 89);
      send_point(123, -456, 359);
      send_point(COORD_MAX, COORD_MIN, -32768);
      send_point(COORD_MIN, COORD_MAX, 32767);
      send_point(0, 0, 17);
   endtask

   task automatic test_pivot_extremes();
      set_pivot(COORD_MIN, COORD_MAX);
      send_point(COORD_MAX, COORD_MIN, 45);
      send_point(COORD_MAX, COORD_MIN, 180);
      send_point(COORD_MIN, COORD_MAX, 77);
      set_pivot(COORD_MAX, COORD_MIN);
      send_point(COORD_MIN, COORD_MAX, 135);
      send_point(COORD_MIN, COORD_MAX, -45);
   endtask

   task automatic test_unused_registers();
      set_pivot(37, -91);
      write_register(CSR_SPARE_A, int'($urandom_range(0, 4095)) - 2048);
      write_register(CSR_SPARE_B, int'($urandom_range(0, 4095)) - 2048);
      send_point(100, 200, 30);
      send_point(COORD_MIN, COORD_MIN, 225);
   endtask

   task automatic test_random_stream();
      for (int phase = 0; phase < 8; phase++) begin
         case (phase)
            0:       set_pivot(COORD_MIN, COORD_MIN);
            1:       set_pivot(COORD_MAX, COORD_MAX);
            2:       set_pivot(COORD_MIN, COORD_MAX);
            3:       set_pivot(0, 0);
            default: set_pivot(int'($urandom_range(0, 4095)) - 2048,
                               int'($urandom_range(0, 4095)) - 2048);
         endcase
         // phase 0 runs with no idling on either side
         gap_max   = (phase % 4) * 6;
         sink_mode = sink_mode_type'(phase % 3);
         repeat (100) send_point(rand_coord(), rand_coord(), rand_angle());
      end
   endtask

   task automatic test_full_pipeline();
      set_pivot(int'($urandom_range(0, 4095)) - 2048, int'($urandom_range(0, 4095)) - 2048);
      gap_max         = 0;
      sink_mode       = SINK_ALWAYS;
      hold_rsp_cycles = LONG_HOLD;
      repeat (80) send_point(rand_coord(), rand_coord(), rand_angle());
   endtask

   task automatic test_drain_restart();
      gap_max   = 5;
      sink_mode = SINK_PATTERN;
      repeat (20) send_point(rand_coord(), rand_coord(), rand_angle());
      drain_rotations();
      sink_mode = SINK_RANDOM;
      repeat (20) send_point(rand_coord(), rand_coord(), rand_angle());
   endtask

   // result side: long hold when asked, otherwise the current stall pattern
   always @(negedge clock) begin
      if (hold_rsp_cycles > 0) begin
         rsp_tready <= 1'b0;
         hold_rsp_cycles = hold_rsp_cycles - 1;
      end else begin
         case (sink_mode)
            SINK_ALWAYS:  rsp_tready <= 1'b1;
            SINK_PATTERN: rsp_tready <= sink_pattern[0];
            default:      rsp_tready <= ($urandom_range(0, 99) < 65);
         endcase
      end
      pattern_age++;
      if (pattern_age == 48) begin
         pattern_age = 0;
         sink_pattern <= 16'($urandom) | 16'h1111;
      end else begin
         sink_pattern <= {sink_pattern[0], sink_pattern[15:1]};
      end
   end

   always @(posedge clock) begin : check_rotations
      rotated_point_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_rotations.size() == 0) begin
            report_mismatch("result with no request pending", rsp_tdata, '0);
         end else begin
            want = pending_rotations.pop_front();
            if (rsp_tdata[OUT_W-1:0] !== want.rot_x)
               report_mismatch("rot_x", rsp_tdata[OUT_W-1:0], want.rot_x);
            if (rsp_tdata[2*OUT_W-1:OUT_W] !== want.rot_y)
               report_mismatch("rot_y", rsp_tdata[2*OUT_W-1:OUT_W], want.rot_y);
            if (rsp_tdata[RSP_DATA_W-1:2*OUT_W] !== '0)
               report_mismatch("padding", rsp_tdata[RSP_DATA_W-1:2*OUT_W], '0);
         end
      end
   end

   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || (csr_valid && csr_ready))
         idle_cycles = 0;
      else
         idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("CHECK FAILED");
         $finish;
      end
   end

   initial begin
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_angle_cases();
      test_pivot_extremes();
      test_unused_registers();
      test_random_stream();
      test_full_pipeline();
      test_drain_restart();
      drain_rotations();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (error_count == 0)
         $display("CHECK OK");
      else
         $display("CHECK FAILED");
      $finish;
   end

endmodule
